// ----- rtl/xec_pkg.sv -----
// ----------------------------------------------------------------------------
// xec_pkg
// Shared constants, entity tables and the job word that travels from the
// front end through the job queue to the byte serializer.
// ----------------------------------------------------------------------------
package xec_pkg;

    localparam int HOLD_DEPTH  = 5;   // longest partial entity that is held
    localparam int NUM_ENT     = 5;   // predefined entities
    localparam int MAX_OUT     = 6;   // most bytes one input byte can cause
    localparam int CNT_W       = 3;   // holds 0..MAX_OUT
    localparam int QUEUE_DEPTH = 2;   // default job queue depth

    typedef logic [7:0] t_byte;

    localparam t_byte CH_AMP  = 8'h26;
    localparam t_byte CH_LT   = 8'h3C;
    localparam t_byte CH_GT   = 8'h3E;
    localparam t_byte CH_APOS = 8'h27;
    localparam t_byte CH_QUOT = 8'h22;
    localparam t_byte CH_SEMI = 8'h3B;
    localparam t_byte CH_NUL  = 8'h00;

    // Entity spellings, first byte at index 0, padded with NUL.
    localparam t_byte ENT_TEXT [NUM_ENT][MAX_OUT] = '{
        '{CH_AMP, "a", "m", "p", CH_SEMI, CH_NUL},
        '{CH_AMP, "l", "t", CH_SEMI, CH_NUL, CH_NUL},
        '{CH_AMP, "g", "t", CH_SEMI, CH_NUL, CH_NUL},
        '{CH_AMP, "a", "p", "o", "s", CH_SEMI},
        '{CH_AMP, "q", "u", "o", "t", CH_SEMI}
    };

    localparam logic [CNT_W-1:0] ENT_LEN [NUM_ENT] = '{3'd5, 3'd4, 3'd4, 3'd6, 3'd6};

    localparam t_byte ENT_PLAIN [NUM_ENT] = '{CH_AMP, CH_LT, CH_GT, CH_APOS, CH_QUOT};

    // One job: the output bytes of one input byte, byte 0 goes out first.
    typedef struct packed {
        logic [MAX_OUT-1:0][7:0] bytes;
        logic [CNT_W-1:0]        cnt;
        logic                    msg_end;
    } t_job;

endpackage

// ----- rtl/xml_entity_codec_core.sv -----
// ----------------------------------------------------------------------------
// xml_entity_codec_core
// Streaming codec for the five predefined XML entities.
// ----------------------------------------------------------------------------
// The block takes one byte per cycle while the job queue has room and gives
// one byte per cycle while the output is not stalled. Each input byte turns
// in the front end, in its cycle of acceptance, into a job of 0 to 6 output
// bytes; the byte serializer in the back end sends one byte per unstalled
// cycle, and a byte that only extends a partial entity pushes no job. A job
// queue of QUEUE_DEPTH entries between the two lets input keep flowing while
// output stalls or expands; input stalls only when that queue is full. With
// mode 1 set by the one configuration bit, entities are decoded, and a
// partial match of up to five bytes is held until it completes, mismatches,
// or the message ends. Writing the mode drops any held bytes; write it only
// when the block is idle.
// ----------------------------------------------------------------------------
module xml_entity_codec_core
    import xec_pkg::*;
#(
    parameter int QUEUE_DEPTH_P = QUEUE_DEPTH
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_cfg_we,
    input  logic       i_cfg_wdata,
    input  logic       i_in_valid,
    output logic       o_in_stall,
    input  logic [7:0] i_in_byte,
    input  logic       i_message_end,
    output logic       o_out_valid,
    input  logic       i_out_stall,
    output logic [7:0] o_out_byte,
    output logic       o_run_last,
    output logic       o_message_last
);

    logic push;
    logic full;
    logic pop;
    logic q_valid;
    t_job f_job;
    t_job q_job;

    xec_front u_front (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_wdata   (i_cfg_wdata),
        .i_valid       (i_in_valid),
        .i_in_byte     (i_in_byte),
        .i_message_end (i_message_end),
        .o_stall       (o_in_stall),
        .i_full        (full),
        .o_push        (push),
        .o_job         (f_job)
    );

    xec_queue #(
        .DEPTH (QUEUE_DEPTH_P)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_job   (f_job),
        .o_full  (full),
        .i_pop   (pop),
        .o_valid (q_valid),
        .o_job   (q_job)
    );

    xec_back u_back (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_q_valid      (q_valid),
        .i_q_job        (q_job),
        .o_pop          (pop),
        .o_out_valid    (o_out_valid),
        .i_out_stall    (i_out_stall),
        .o_out_byte     (o_out_byte),
        .o_run_last     (o_run_last),
        .o_message_last (o_message_last)
    );

endmodule

// ----- rtl/xec_front.sv -----
// ----------------------------------------------------------------------------
// xec_front
// Accepts input bytes, tracks the partial entity match and turns each byte
// into one job word holding all of its output bytes.
// ----------------------------------------------------------------------------
module xec_front
    import xec_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic        i_cfg_wdata,
    input  logic        i_valid,
    input  logic [7:0]  i_in_byte,
    input  logic        i_message_end,
    output logic        o_stall,
    input  logic        i_full,
    output logic        o_push,
    output t_job        o_job
);

    logic             r_mode;
    t_byte            r_held [HOLD_DEPTH];
    logic [CNT_W-1:0] r_hcnt;

    t_byte            n_held [HOLD_DEPTH];
    logic [CNT_W-1:0] n_hcnt;

    logic                      accept;
    logic                      esc_hit;
    logic [CNT_W-1:0]          esc_sel;
    logic [NUM_ENT-1:0]        ent_ok;
    logic                      m_hit;
    logic                      m_full;
    logic [CNT_W-1:0]          m_sel;
    t_byte                     a_list [MAX_OUT];
    logic [CNT_W-1:0]          a_cnt;
    logic [CNT_W:0]            tot_cnt;
    logic                      is_amp;
    t_job                      job;

    assign accept  = i_valid && !o_stall;
    assign o_stall = i_full;
    assign is_amp  = (i_in_byte == CH_AMP);

    // Escape lookup
    always_comb begin
        esc_hit = 1'b0;
        esc_sel = '0;
        for (int e = NUM_ENT - 1; e >= 0; e--) begin
            if (ENT_PLAIN[e] == i_in_byte) begin
                esc_hit = 1'b1;
                esc_sel = CNT_W'(e);
            end
        end
    end

    // Held prefix plus new byte against each entity, lowest index wins
    always_comb begin
        logic pre;
        logic tail;
        logic [CNT_W:0] need;
        need = {1'b0, r_hcnt} + (CNT_W+1)'(1);
        for (int e = 0; e < NUM_ENT; e++) begin
            pre  = 1'b1;
            tail = 1'b0;
            for (int i = 0; i < HOLD_DEPTH; i++) begin
                if (i < int'(r_hcnt) && r_held[i] != ENT_TEXT[e][i])
                    pre = 1'b0;
            end
            for (int i = 0; i < MAX_OUT; i++) begin
                if (i == int'(r_hcnt) && ENT_TEXT[e][i] == i_in_byte)
                    tail = 1'b1;
            end
            ent_ok[e] = pre && tail && (need <= {1'b0, ENT_LEN[e]});
        end
        m_hit  = 1'b0;
        m_sel  = '0;
        for (int e = NUM_ENT - 1; e >= 0; e--) begin
            if (ent_ok[e]) begin
                m_hit = 1'b1;
                m_sel = CNT_W'(e);
            end
        end
        m_full = m_hit && (need == {1'b0, ENT_LEN[m_sel]});
    end

    // Build the job for this byte
    always_comb begin
        n_held = r_held;
        n_hcnt = r_hcnt;
        a_cnt  = '0;
        for (int k = 0; k < MAX_OUT; k++)
            a_list[k] = i_in_byte;

        if (!r_mode) begin
            if (esc_hit) begin
                for (int k = 0; k < MAX_OUT; k++)
                    a_list[k] = ENT_TEXT[esc_sel][k];
                a_cnt = ENT_LEN[esc_sel];
            end else begin
                a_cnt = CNT_W'(1);
            end
        end else if (m_full) begin
            a_list[0] = ENT_PLAIN[m_sel];
            a_cnt     = CNT_W'(1);
            n_hcnt    = '0;
        end else if (m_hit) begin
            for (int i = 0; i < HOLD_DEPTH; i++)
                if (i == int'(r_hcnt))
                    n_held[i] = i_in_byte;
            n_hcnt = CNT_W'(r_hcnt + CNT_W'(1));
        end else begin
            // mismatch: release the held bytes, then the new byte or a new match
            for (int i = 0; i < HOLD_DEPTH; i++)
                if (i < int'(r_hcnt))
                    a_list[i] = r_held[i];
            if (is_amp) begin
                a_cnt     = r_hcnt;
                n_held[0] = CH_AMP;
                n_hcnt    = CNT_W'(1);
            end else begin
                a_cnt  = CNT_W'(r_hcnt + CNT_W'(1));
                n_hcnt = '0;
            end
        end

        // message end in decode mode: append what is still held
        tot_cnt = {1'b0, a_cnt};
        for (int k = 0; k < MAX_OUT; k++)
            job.bytes[k] = a_list[k];
        if (r_mode && i_message_end) begin
            for (int k = 0; k < MAX_OUT; k++) begin
                for (int j = 0; j < HOLD_DEPTH; j++) begin
                    if (k >= int'(a_cnt) && (k - int'(a_cnt)) == j)
                        job.bytes[k] = n_held[j];
                end
            end
            tot_cnt = {1'b0, a_cnt} + {1'b0, n_hcnt};
            n_hcnt  = '0;
        end
        job.cnt     = tot_cnt[CNT_W-1:0];
        job.msg_end = i_message_end;
    end

    assign o_job  = job;
    assign o_push = accept && (job.cnt != '0);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode <= 1'b0;
            r_hcnt <= '0;
        end else if (i_cfg_we) begin
            r_mode <= i_cfg_wdata;
            r_hcnt <= '0;
        end else if (accept) begin
            r_hcnt <= n_hcnt;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept)
            r_held <= n_held;
    end

    a_hold_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_hcnt <= CNT_W'(HOLD_DEPTH))
        else $error("held count beyond hold depth");

    a_escape_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !r_mode |-> r_hcnt == '0)
        else $error("bytes held in escape mode");

    a_end_flushes: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        accept && i_message_end |-> o_push ##1 r_hcnt == '0)
        else $error("message end left bytes held or produced no job");

endmodule

// ----- rtl/xec_queue.sv -----
// ----------------------------------------------------------------------------
// xec_queue
// Small job queue in flops between front end and serializer.
// ----------------------------------------------------------------------------
module xec_queue
    import xec_pkg::*;
#(
    parameter int DEPTH = QUEUE_DEPTH
) (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_push,
    input  t_job i_job,
    output logic o_full,
    input  logic i_pop,
    output logic o_valid,
    output t_job o_job
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_Q = $clog2(DEPTH + 1);

    t_job             r_mem [DEPTH];
    logic [PTR_W-1:0] r_wr;
    logic [PTR_W-1:0] r_rd;
    logic [CNT_Q-1:0] r_cnt;

    logic [PTR_W-1:0] n_wr;
    logic [PTR_W-1:0] n_rd;
    logic [CNT_Q-1:0] n_cnt;

    assign o_full  = (r_cnt == CNT_Q'(DEPTH));
    assign o_valid = (r_cnt != '0);
    assign o_job   = r_mem[r_rd];

    always_comb begin
        n_wr  = r_wr;
        n_rd  = r_rd;
        n_cnt = r_cnt;
        if (i_push)
            n_wr = (r_wr == PTR_W'(DEPTH - 1)) ? '0 : PTR_W'(r_wr + PTR_W'(1));
        if (i_pop)
            n_rd = (r_rd == PTR_W'(DEPTH - 1)) ? '0 : PTR_W'(r_rd + PTR_W'(1));
        if (i_push && !i_pop)
            n_cnt = CNT_Q'(r_cnt + CNT_Q'(1));
        else if (i_pop && !i_push)
            n_cnt = CNT_Q'(r_cnt - CNT_Q'(1));
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            r_wr  <= n_wr;
            r_rd  <= n_rd;
            r_cnt <= n_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push)
            r_mem[r_wr] <= i_job;
    end

    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_full |-> !i_push)
        else $error("push into full job queue");

    a_no_underflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_valid |-> !i_pop)
        else $error("pop from empty job queue");

endmodule

// ----- rtl/xec_back.sv -----
// ----------------------------------------------------------------------------
// xec_back
// Byte serializer: loads one job at a time and sends its bytes one per
// output word, marking the last byte of the job and of the message.
// ----------------------------------------------------------------------------
module xec_back
    import xec_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_q_valid,
    input  t_job       i_q_job,
    output logic       o_pop,
    output logic       o_out_valid,
    input  logic       i_out_stall,
    output logic [7:0] o_out_byte,
    output logic       o_run_last,
    output logic       o_message_last
);

    logic                    r_valid;
    logic [MAX_OUT-1:0][7:0] r_bytes;
    logic [CNT_W-1:0]        r_left;
    logic                    r_msg;

    logic take;
    logic last_byte;

    assign take      = r_valid && !i_out_stall;
    assign last_byte = (r_left == CNT_W'(1));
    // load the next job when idle or while the final byte leaves
    assign o_pop     = i_q_valid && (!r_valid || (take && last_byte));

    assign o_out_valid    = r_valid;
    assign o_out_byte     = r_bytes[0];
    assign o_run_last     = last_byte;
    assign o_message_last = last_byte && r_msg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
            r_left  <= '0;
        end else if (o_pop) begin
            r_valid <= 1'b1;
            r_left  <= i_q_job.cnt;
        end else if (take) begin
            r_valid <= !last_byte;
            r_left  <= CNT_W'(r_left - CNT_W'(1));
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_bytes <= i_q_job.bytes;
            r_msg   <= i_q_job.msg_end;
        end else if (take) begin
            r_bytes <= r_bytes >> 8;
        end
    end

    a_left_live: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_valid |-> (r_left != '0 && r_left <= CNT_W'(MAX_OUT)))
        else $error("serializer holds a job with no bytes left");

endmodule

// ----- verif/xec_checker.sv -----
// ----------------------------------------------------------------------------
// xec_checker
// Watches both channels and the mode port of the entity codec. Each input
// word is run through a model of the escape and unescape rules, and each
// output word is compared with the oldest predicted word.
// ----------------------------------------------------------------------------
package xec_tb_pkg;

    typedef enum logic {
        MODE_ESCAPE   = 1'b0,
        MODE_UNESCAPE = 1'b1
    } t_mode;

endpackage

module xec_checker
    import xec_pkg::*, xec_tb_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_cfg_we,
    input  logic       i_cfg_wdata,
    input  logic       i_in_valid,
    input  logic       i_in_stall,
    input  logic [7:0] i_in_byte,
    input  logic       i_message_end,
    input  logic       i_out_valid,
    input  logic       i_out_stall,
    input  logic [7:0] i_out_byte,
    input  logic       i_run_last,
    input  logic       i_message_last,
    output int         o_mismatch_count,
    output int         o_words_pending
);
    timeunit 1ns;
    timeprecision 1ps;

    typedef struct packed {
        t_byte data;
        logic  run_last;
        logic  msg_last;
    } t_out_word;

    localparam int SPELL_MAX = 6;

    localparam t_byte SPELL [NUM_ENT][SPELL_MAX] = '{
        '{"&", "a", "m", "p", ";", 8'h00},
        '{"&", "l", "t", ";", 8'h00, 8'h00},
        '{"&", "g", "t", ";", 8'h00, 8'h00},
        '{"&", "a", "p", "o", "s", ";"},
        '{"&", "q", "u", "o", "t", ";"}
    };
    localparam int    SPELL_LEN [NUM_ENT] = '{5, 4, 4, 6, 6};
    localparam t_byte PLAIN     [NUM_ENT] = '{CH_AMP, CH_LT, CH_GT, CH_APOS, CH_QUOT};

    t_mode     mode_q = MODE_ESCAPE;
    t_byte     held_q [HOLD_DEPTH];
    int        held_n = 0;
    t_out_word expected_words[$];
    t_out_word step_words[$];
    int        mismatch_count = 0;
    int        pending_n = 0;

    assign o_mismatch_count = mismatch_count;
    assign o_words_pending  = pending_n;

    function automatic void push_word(input t_byte b);
        t_out_word w;
        w = '{data: b, run_last: 1'b0, msg_last: 1'b0};
        step_words.insert(step_words.size(), w);
    endfunction

    function automatic void flush_held();
        int i;
        for (i = 0; i < held_n; i++) push_word(held_q[i]);
        held_n = 0;
    endfunction

    // Work out the output words of one input word and queue them.
    function automatic void codec_predict(input t_byte b, input logic last);
        int e, i, hit;
        bit full, ok;
        step_words.delete();
        hit  = -1;
        full = 1'b0;
        if (mode_q == MODE_ESCAPE) begin
            for (e = 0; e < NUM_ENT; e++)
                if (hit < 0 && PLAIN[e] == b) hit = e;
            if (hit >= 0) begin
                for (i = 0; i < SPELL_LEN[hit]; i++) push_word(SPELL[hit][i]);
            end else begin
                push_word(b);
            end
        end else begin
            // First entity whose spelling starts with the held bytes plus b.
            for (e = 0; e < NUM_ENT; e++) begin
                if (hit < 0 && held_n + 1 <= SPELL_LEN[e]) begin
                    ok = 1'b1;
                    for (i = 0; i < held_n; i++)
                        if (held_q[i] != SPELL[e][i]) ok = 1'b0;
                    if (ok && SPELL[e][held_n] == b) begin
                        hit  = e;
                        full = (held_n + 1 == SPELL_LEN[e]);
                    end
                end
            end
            if (hit >= 0) begin
                if (full) begin
                    push_word(PLAIN[hit]);
                    held_n = 0;
                end else if (held_n < HOLD_DEPTH) begin
                    held_q[held_n] = b;
                    held_n++;
                end
            end else begin
                flush_held();
                if (b == CH_AMP) begin
                    held_q[0] = b;
                    held_n    = 1;
                end else begin
                    push_word(b);
                end
            end
            if (last) flush_held();
        end
        if (step_words.size() > 0) begin
            step_words[step_words.size() - 1].run_last = 1'b1;
            step_words[step_words.size() - 1].msg_last = last;
        end
        for (i = 0; i < step_words.size(); i++)
            expected_words.insert(expected_words.size(), step_words[i]);
    endfunction

    always @(posedge i_clk) begin
        t_out_word want;
        bit        bad;
        if (!i_rst_n) begin
            mode_q = MODE_ESCAPE;
            held_n = 0;
            expected_words.delete();
        end else begin
            if (i_cfg_we) begin
                mode_q = t_mode'(i_cfg_wdata);
                held_n = 0;
            end
            if (i_in_valid && !i_in_stall) codec_predict(i_in_byte, i_message_end);
            if (i_out_valid && !i_out_stall) begin
                if (expected_words.size() == 0) begin
                    $display("%0t: unexpected word: expected none, got byte %h run_last %b message_last %b",
                             $time, i_out_byte, i_run_last, i_message_last);
                    mismatch_count++;
                end else begin
                    want = expected_words.pop_front();
                    bad  = 1'b0;
                    if (i_out_byte !== want.data) begin
                        $display("%0t: out_byte expected %h got %h", $time, want.data, i_out_byte);
                        bad = 1'b1;
                    end
                    if (i_run_last !== want.run_last) begin
                        $display("%0t: run_last expected %b got %b", $time, want.run_last, i_run_last);
                        bad = 1'b1;
                    end
                    if (i_message_last !== want.msg_last) begin
                        $display("%0t: message_last expected %b got %b",
                                 $time, want.msg_last, i_message_last);
                        bad = 1'b1;
                    end
                    if (bad) mismatch_count++;
                end
            end
        end
        pending_n = expected_words.size();
    end

endmodule

// ----- verif/tb_top.sv -----
// ----------------------------------------------------------------------------
// tb_top
// Drives text through the entity codec in both modes: a short directed
// sequence of edge cases, then random text with well-formed entities,
// broken ones and noise, with random gaps on input and stalls on output.
// ----------------------------------------------------------------------------
module tb_top
    import xec_pkg::*, xec_tb_pkg::*;
;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int CYCLE_LIMIT  = 1000000;
    localparam int DRAIN_CYCLES = 16;
    localparam int RANDOM_WORDS = 480;

    logic       clk = 1'b0;
    logic       rst_n = 1'b0;
    logic       cfg_we = 1'b0;
    logic       cfg_wdata = 1'b0;
    logic       in_valid = 1'b0;
    logic       in_stall;
    logic [7:0] in_byte = 8'h00;
    logic       message_end = 1'b0;
    logic       out_valid;
    logic       out_stall = 1'b0;
    logic [7:0] out_byte;
    logic       run_last;
    logic       message_last;

    int mismatch_count;
    int words_pending;
    int cycle_count = 0;
    int words_sent = 0;
    int calm_left = 0;
    int stall_left = 0;
    int run_left = 0;

    xml_entity_codec_core DUT (
        .i_clk          (clk),
        .i_rst_n        (rst_n),
        .i_cfg_we       (cfg_we),
        .i_cfg_wdata    (cfg_wdata),
        .i_in_valid     (in_valid),
        .o_in_stall     (in_stall),
        .i_in_byte      (in_byte),
        .i_message_end  (message_end),
        .o_out_valid    (out_valid),
        .i_out_stall    (out_stall),
        .o_out_byte     (out_byte),
        .o_run_last     (run_last),
        .o_message_last (message_last)
    );

    xec_checker u_checker (
        .i_clk            (clk),
        .i_rst_n          (rst_n),
        .i_cfg_we         (cfg_we),
        .i_cfg_wdata      (cfg_wdata),
        .i_in_valid       (in_valid),
        .i_in_stall       (in_stall),
        .i_in_byte        (in_byte),
        .i_message_end    (message_end),
        .i_out_valid      (out_valid),
        .i_out_stall      (out_stall),
        .i_out_byte       (out_byte),
        .i_run_last       (run_last),
        .i_message_last   (message_last),
        .o_mismatch_count (mismatch_count),
        .o_words_pending  (words_pending)
    );

    always #10 clk = ~clk;

    always @(posedge clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("*** FAILED ***");
            $finish;
        end
    end

    // Output backpressure: short runs and stalls, now and then a long stall
    // or a long stretch with none.
    always @(negedge clk) begin : stall_gen
        int r;
        r = $urandom_range(0, 19);
        if (stall_left > 0) begin
            stall_left <= stall_left - 1;
            out_stall  <= 1'b1;
        end else if (run_left > 0) begin
            run_left  <= run_left - 1;
            out_stall <= 1'b0;
        end else begin
            out_stall  <= 1'b0;
            run_left   <= ($urandom_range(0, 9) == 0) ? $urandom_range(40, 150)
                                                      : $urandom_range(0, 6);
            stall_left <= (r < 15) ? $urandom_range(1, 2)
                        : (r < 19) ? $urandom_range(3, 8) : $urandom_range(15, 40);
        end
    end

    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (calm_left > 0) begin
            calm_left--;
            return 0;
        end
        if (r < 3) begin
            calm_left = $urandom_range(20, 60);
            return 0;
        end
        if (r < 60) return 0;
        if (r < 88) return $urandom_range(1, 3);
        if (r < 97) return $urandom_range(4, 10);
        return $urandom_range(20, 40);
    endfunction

    function automatic bit pick_end();
        return ($urandom_range(0, 9) == 0);
    endfunction

    // Present one word, hold it until taken, then idle for a random gap.
    task automatic send_word(input t_byte b, input bit last);
        int gap;
        @(negedge clk);
        in_valid    <= 1'b1;
        in_byte     <= b;
        message_end <= last;
        @(posedge clk);
        while (in_stall) @(posedge clk);
        words_sent++;
        gap = pick_gap();
        if (gap > 0) begin
            @(negedge clk);
            in_valid    <= 1'b0;
            in_byte     <= t_byte'($urandom_range(0, 255));
            message_end <= 1'($urandom_range(0, 1));
            repeat (gap - 1) @(negedge clk);
        end
    endtask

    task automatic send_text(input string s, input bit end_on_last);
        int i;
        for (i = 0; i < s.len(); i++)
            send_word(t_byte'(s[i]), end_on_last && (i == s.len() - 1));
    endtask

    // Drop valid and wait until every predicted word has come out.
    task automatic settle();
        @(negedge clk);
        in_valid <= 1'b0;
        while (words_pending != 0) @(negedge clk);
        repeat (DRAIN_CYCLES) @(negedge clk);
    endtask

    task automatic write_mode(input t_mode m);
        settle();
        @(negedge clk);
        cfg_we    <= 1'b1;
        cfg_wdata <= m;
        @(negedge clk);
        cfg_we    <= 1'b0;
    endtask

    task automatic random_decode_chunk();
        int kind, e, k, i;
        kind = $urandom_range(0, 9);
        e    = $urandom_range(0, NUM_ENT - 1);
        if (kind < 5) begin
            for (i = 0; i < int'(ENT_LEN[e]); i++) send_word(ENT_TEXT[e][i], pick_end());
        end else if (kind < 7) begin
            // Broken entity: a prefix, then a stray byte or a fresh ampersand.
            k = $urandom_range(1, int'(ENT_LEN[e]) - 1);
            for (i = 0; i < k; i++) send_word(ENT_TEXT[e][i], pick_end());
            send_word($urandom_range(0, 1) ? CH_AMP : t_byte'($urandom_range(0, 255)), pick_end());
        end else if (kind == 7) begin
            send_word(CH_AMP, pick_end());
        end else begin
            send_word(t_byte'($urandom_range(0, 255)), pick_end());
        end
    endtask

    task automatic random_escape_chunk();
        if ($urandom_range(0, 9) < 4)
            send_word(ENT_PLAIN[$urandom_range(0, NUM_ENT - 1)], pick_end());
        else
            send_word(t_byte'($urandom_range(0, 255)), pick_end());
    endtask

    initial begin
        t_mode phase_mode [4] = '{MODE_UNESCAPE, MODE_ESCAPE, MODE_UNESCAPE, MODE_ESCAPE};
        int p, target;
        repeat (6) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        write_mode(MODE_ESCAPE);
        send_word(8'h00, 1'b0);
        send_word(8'hFF, 1'b0);
        send_word(CH_AMP, 1'b0);
        send_word(CH_LT, 1'b0);
        send_word(CH_GT, 1'b0);
        send_word(CH_APOS, 1'b0);
        send_word(CH_QUOT, 1'b0);
        send_word("x", 1'b1);

        write_mode(MODE_UNESCAPE);
        send_text("&apos;", 1'b0);
        // Mismatching ampersand restarts the match.
        send_text("&a&lt;", 1'b0);
        // Message ends on a partial entity: flush it.
        send_text("&q", 1'b1);
        // Partial entity held across a mode write: the write discards it.
        send_text("&qu", 1'b0);
        write_mode(MODE_UNESCAPE);
        send_text("t;", 1'b1);

        for (p = 0; p < 4; p++) begin
            write_mode(phase_mode[p]);
            target = words_sent + RANDOM_WORDS / 4;
            while (words_sent < target) begin
                if (phase_mode[p] == MODE_UNESCAPE)
                    random_decode_chunk();
                else
                    random_escape_chunk();
            end
        end

        settle();
        if (mismatch_count == 0 && words_pending == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

endmodule
